### rtl/core/vrrl_pkg.sv
// Package for the variable-length record ring log: constants, types, codes.
package vrrl_pkg;

    localparam int RingBytes = 4096;
    localparam int AddrW = $clog2(RingBytes);
    localparam int UsedW = AddrW + 1;
    localparam int LenBytes = 4;
    localparam int SeqBytes = 4;
    localparam int FrameBytes = LenBytes * 2 + SeqBytes;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [UsedW-1:0] t_used;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FIND  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NONE     = 2'd2,
        ST_FOUND    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_EV_LOAD,
        S_EV_STEP,
        S_PUSH_WR,
        S_FIND_TLEN,
        S_FIND_CHK,
        S_FIND_SEQ,
        S_FIND_CMP,
        S_FIND_OLD,
        S_FIND_OSEQ,
        S_BYTE_RD,
        S_DONE
    } t_state;

    // Memory access request from the sequencer to the byte engine.
    typedef struct packed {
        logic        start;
        logic        wr;
        logic [2:0]  nbytes;
        t_addr       addr;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

### rtl/core/vrrl_byte_engine.sv
// Byte ring storage with a multi-byte little-endian load/store sequencer.
module vrrl_byte_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrrl_pkg::t_mem_req i_req,
    output logic              o_busy,
    output logic              o_done,
    output logic [31:0]       o_rdata
);
    logic [7:0] r_mem [vrrl_pkg::RingBytes];
    logic [7:0] r_q;
    logic       r_busy, n_busy;
    logic       r_wr;
    logic [2:0] r_cnt, n_cnt, r_num;
    logic       r_rdv, n_rdv;
    vrrl_pkg::t_addr r_addr, n_addr;
    logic [31:0] r_wdata, r_data, n_data;
    logic       r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (r_busy && r_wr && r_cnt != r_num) begin
            r_mem[r_addr] <= r_wdata[8*r_cnt +: 8];
        end
        r_q <= r_mem[r_addr];
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_addr = r_addr;
        n_rdv  = 1'b0;
        n_data = r_data;
        n_done = 1'b0;
        if (r_rdv) begin
            n_data[8*(r_cnt - 3'd1) +: 8] = r_q;
        end
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_addr = i_req.addr;
            n_data = '0;
        end else if (r_busy) begin
            if (r_cnt == r_num) begin
                if (r_wr || !r_rdv) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                n_rdv  = !r_wr;
                n_cnt  = r_cnt + 3'd1;
                n_addr = r_addr + vrrl_pkg::AddrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_rdv  <= n_rdv;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_addr <= n_addr;
        r_data <= n_data;
        if (i_req.start && !r_busy) begin
            r_wr    <= i_req.wr;
            r_num   <= i_req.nbytes;
            r_wdata <= i_req.wdata;
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_rdata = r_data;
endmodule

### rtl/core/variable_record_ring_log.sv
// Top level of the variable-length record ring log: sequencer and result register.
//   channel | direction | handshake           | fields
//   request | in        | i_valid / o_ready   | req_type entry_len byte_offset write_data last_seq
//   result  | out       | o_valid / i_ready   | status offset_out found_len found_seq read_data
// One request at a time; the byte engine moves one ring byte per cycle while a field
// load or store is in progress. A push first evicts oldest records until the new one
// fits; a find walks records backward from the newest and falls back to the oldest
// record. Reset clears the pointers, sequence counter and control state; ring contents
// stay undefined. The result is held until i_ready takes it; o_ready returns once r_ov
// has cleared and the sequencer has left S_DONE.
module variable_record_ring_log (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_entry_len,
    input  logic [11:0] i_byte_offset,
    input  logic [7:0]  i_write_data,
    input  logic [31:0] i_last_seq,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_offset_out,
    output logic [15:0] o_found_len,
    output logic [31:0] o_found_seq,
    output logic [7:0]  o_read_data
);
    vrrl_pkg::t_state r_state, n_state;
    vrrl_pkg::t_mem_req mreq;
    logic        m_busy, m_done;
    logic [31:0] m_rdata;

    logic [1:0]  r_req;
    logic [15:0] r_len;
    vrrl_pkg::t_addr r_boff;
    logic [7:0]  r_wd;
    logic [31:0] r_want;

    vrrl_pkg::t_addr r_oldest;
    vrrl_pkg::t_used r_used;
    logic [31:0] r_seq;

    vrrl_pkg::t_used r_left;     // walk position
    logic [1:0]  r_wstep;        // push framing write step
    logic        r_issued;
    logic [31:0] r_tlen;
    vrrl_pkg::t_addr r_rec;

    logic [1:0]  r_st;
    vrrl_pkg::t_addr r_off;
    logic [15:0] r_flen;
    logic [31:0] r_fseq;
    logic [7:0]  r_rd;
    logic        r_ov;

    logic [16:0] total_in;
    logic [32:0] total_t;
    vrrl_pkg::t_addr wpos;

    assign total_in = {1'b0, i_entry_len} + 17'(vrrl_pkg::FrameBytes);
    assign total_t  = {1'b0, r_tlen} + 33'(vrrl_pkg::FrameBytes);
    assign wpos     = r_oldest + r_used[vrrl_pkg::AddrW-1:0];

    vrrl_byte_engine u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_busy  (m_busy),
        .o_done  (m_done),
        .o_rdata (m_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vrrl_pkg::S_IDLE:     if (i_valid) n_state = vrrl_pkg::S_DISPATCH;
            vrrl_pkg::S_DISPATCH: begin
                case (vrrl_pkg::t_req'(r_req))
                    vrrl_pkg::REQ_PUSH: begin
                        if ({1'b0, r_len} + 17'(vrrl_pkg::FrameBytes) > 17'(vrrl_pkg::RingBytes))
                            n_state = vrrl_pkg::S_DONE;
                        else
                            n_state = vrrl_pkg::S_EV_LOAD;
                    end
                    vrrl_pkg::REQ_FIND:
                        n_state = (r_used == '0) ? vrrl_pkg::S_DONE : vrrl_pkg::S_FIND_TLEN;
                    default: n_state = vrrl_pkg::S_BYTE_RD;
                endcase
            end
            vrrl_pkg::S_EV_LOAD: begin
                if (17'(vrrl_pkg::RingBytes) - 17'(r_used)
                        >= {1'b0, r_len} + 17'(vrrl_pkg::FrameBytes))
                    n_state = vrrl_pkg::S_PUSH_WR;
                else if (r_issued && m_done)
                    n_state = vrrl_pkg::S_EV_STEP;
            end
            vrrl_pkg::S_EV_STEP: n_state = vrrl_pkg::S_EV_LOAD;
            vrrl_pkg::S_PUSH_WR:
                if (r_issued && m_done && r_wstep == 2'd2) n_state = vrrl_pkg::S_DONE;
            vrrl_pkg::S_FIND_TLEN: if (r_issued && m_done) n_state = vrrl_pkg::S_FIND_CHK;
            vrrl_pkg::S_FIND_CHK:
                n_state = (total_t > 33'(r_left)) ? vrrl_pkg::S_FIND_OLD : vrrl_pkg::S_FIND_SEQ;
            vrrl_pkg::S_FIND_SEQ: if (r_issued && m_done) n_state = vrrl_pkg::S_FIND_CMP;
            vrrl_pkg::S_FIND_CMP: begin
                if (r_fseq == r_want && r_left == r_used) n_state = vrrl_pkg::S_DONE;
                else if (r_fseq == r_want + 32'd1) n_state = vrrl_pkg::S_DONE;
                else if (33'(r_left) == total_t)
                    n_state = vrrl_pkg::S_FIND_OLD;
                else n_state = vrrl_pkg::S_FIND_TLEN;
            end
            vrrl_pkg::S_FIND_OLD:  if (r_issued && m_done) n_state = vrrl_pkg::S_FIND_OSEQ;
            vrrl_pkg::S_FIND_OSEQ: if (r_issued && m_done) n_state = vrrl_pkg::S_DONE;
            vrrl_pkg::S_BYTE_RD:   if (r_issued && m_done) n_state = vrrl_pkg::S_DONE;
            vrrl_pkg::S_DONE:      if (!r_ov) n_state = vrrl_pkg::S_IDLE;
            default: n_state = vrrl_pkg::S_IDLE;
        endcase
    end

    // engine request
    always_comb begin
        mreq = '0;
        mreq.start = !r_issued && !m_busy;
        case (r_state)
            vrrl_pkg::S_EV_LOAD: begin
                mreq.nbytes = 3'(vrrl_pkg::LenBytes);
                mreq.addr   = r_oldest;
                if (17'(vrrl_pkg::RingBytes) - 17'(r_used)
                        >= {1'b0, r_len} + 17'(vrrl_pkg::FrameBytes))
                    mreq.start = 1'b0;
            end
            vrrl_pkg::S_PUSH_WR: begin
                mreq.wr = 1'b1;
                case (r_wstep)
                    2'd0: begin
                        mreq.nbytes = 3'(vrrl_pkg::LenBytes);
                        mreq.addr   = wpos;
                        mreq.wdata  = {16'd0, r_len};
                    end
                    2'd1: begin
                        mreq.nbytes = 3'(vrrl_pkg::SeqBytes);
                        mreq.addr   = wpos + vrrl_pkg::AddrW'(vrrl_pkg::LenBytes);
                        mreq.wdata  = r_seq;
                    end
                    default: begin
                        mreq.nbytes = 3'(vrrl_pkg::LenBytes);
                        mreq.addr   = wpos + vrrl_pkg::AddrW'(vrrl_pkg::LenBytes
                                      + vrrl_pkg::SeqBytes) + r_len[vrrl_pkg::AddrW-1:0];
                        mreq.wdata  = {16'd0, r_len};
                    end
                endcase
            end
            vrrl_pkg::S_FIND_TLEN: begin
                mreq.nbytes = 3'(vrrl_pkg::LenBytes);
                mreq.addr   = r_oldest + r_left[vrrl_pkg::AddrW-1:0]
                              - vrrl_pkg::AddrW'(vrrl_pkg::LenBytes);
            end
            vrrl_pkg::S_FIND_SEQ: begin
                mreq.nbytes = 3'(vrrl_pkg::SeqBytes);
                mreq.addr   = r_rec + vrrl_pkg::AddrW'(vrrl_pkg::LenBytes);
            end
            vrrl_pkg::S_FIND_OLD: begin
                mreq.nbytes = 3'(vrrl_pkg::LenBytes);
                mreq.addr   = r_oldest;
            end
            vrrl_pkg::S_FIND_OSEQ: begin
                mreq.nbytes = 3'(vrrl_pkg::SeqBytes);
                mreq.addr   = r_oldest + vrrl_pkg::AddrW'(vrrl_pkg::LenBytes);
            end
            vrrl_pkg::S_BYTE_RD: begin
                mreq.wr     = (r_req == vrrl_pkg::REQ_WRITE);
                mreq.nbytes = 3'd1;
                mreq.addr   = r_boff;
                mreq.wdata  = {24'd0, r_wd};
            end
            default: mreq.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vrrl_pkg::S_IDLE;
            r_oldest <= '0;
            r_used   <= '0;
            r_seq    <= '0;
            r_ov     <= 1'b0;
            r_issued <= 1'b0;
            r_wstep  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (mreq.start) r_issued <= 1'b1;
            if (m_done) r_issued <= 1'b0;
            if (o_valid && i_ready) r_ov <= 1'b0;
            case (r_state)
                vrrl_pkg::S_IDLE: if (i_valid) begin
                    r_req  <= i_req_type;
                    r_len  <= i_entry_len;
                    r_boff <= i_byte_offset;
                    r_wd   <= i_write_data;
                    r_want <= i_last_seq;
                    r_st   <= vrrl_pkg::ST_OK;
                    r_off  <= '0;
                    r_flen <= '0;
                    r_fseq <= '0;
                    r_rd   <= '0;
                    r_wstep <= 2'd0;
                    r_left <= r_used;
                end
                vrrl_pkg::S_DISPATCH: begin
                    if (r_req == vrrl_pkg::REQ_PUSH) begin
                        if (n_state == vrrl_pkg::S_DONE) r_st <= vrrl_pkg::ST_TOO_BIG;
                        else r_seq <= r_seq + 32'd1;
                    end
                    if (r_req == vrrl_pkg::REQ_FIND) r_st <= vrrl_pkg::ST_NONE;
                end
                vrrl_pkg::S_EV_LOAD: if (r_issued && m_done) r_tlen <= m_rdata;
                vrrl_pkg::S_EV_STEP: begin
                    if (total_t < 33'(r_used)) begin
                        r_oldest <= r_oldest + total_t[vrrl_pkg::AddrW-1:0];
                        r_used   <= r_used - total_t[vrrl_pkg::UsedW-1:0];
                    end else begin
                        r_oldest <= r_oldest + r_used[vrrl_pkg::AddrW-1:0];
                        r_used   <= '0;
                    end
                end
                vrrl_pkg::S_PUSH_WR: if (r_issued && m_done) begin
                    r_wstep <= r_wstep + 2'd1;
                    if (r_wstep == 2'd2) begin
                        r_off  <= wpos + vrrl_pkg::AddrW'(vrrl_pkg::LenBytes
                                  + vrrl_pkg::SeqBytes);
                        r_fseq <= r_seq;
                        r_used <= r_used + vrrl_pkg::UsedW'(r_len)
                                  + vrrl_pkg::UsedW'(vrrl_pkg::FrameBytes);
                    end
                end
                vrrl_pkg::S_FIND_TLEN: if (r_issued && m_done) r_tlen <= m_rdata;
                vrrl_pkg::S_FIND_CHK:
                    r_rec <= r_oldest + r_left[vrrl_pkg::AddrW-1:0]
                             - total_t[vrrl_pkg::AddrW-1:0];
                vrrl_pkg::S_FIND_SEQ: if (r_issued && m_done) r_fseq <= m_rdata;
                vrrl_pkg::S_FIND_CMP: begin
                    if (r_fseq == r_want && r_left == r_used) begin
                        r_fseq <= '0;
                    end else if (r_fseq == r_want + 32'd1) begin
                        r_st   <= vrrl_pkg::ST_FOUND;
                        r_off  <= r_rec;
                        r_flen <= r_tlen[15:0];
                    end else begin
                        r_left <= r_left - total_t[vrrl_pkg::UsedW-1:0];
                    end
                end
                vrrl_pkg::S_FIND_OLD: if (r_issued && m_done) begin
                    r_flen <= m_rdata[15:0];
                    r_off  <= r_oldest;
                    r_st   <= vrrl_pkg::ST_FOUND;
                end
                vrrl_pkg::S_FIND_OSEQ: if (r_issued && m_done) r_fseq <= m_rdata;
                vrrl_pkg::S_BYTE_RD: if (r_issued && m_done && r_req == vrrl_pkg::REQ_READ)
                    r_rd <= m_rdata[7:0];
                default: ;
            endcase
            if (n_state == vrrl_pkg::S_DONE && r_state != vrrl_pkg::S_DONE) r_ov <= 1'b1;
        end
    end

    assign o_ready      = (r_state == vrrl_pkg::S_IDLE);
    assign o_valid      = r_ov;
    assign o_status     = r_st;
    assign o_offset_out = r_off;
    assign o_found_len  = r_flen;
    assign o_found_seq  = r_fseq;
    assign o_read_data  = r_rd;
endmodule
